/* rtl/core/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Characters for one input byte, from the front to the back.
    typedef struct packed {
        logic [5:0] sx0;
        logic [5:0] sx1;
        logic [1:0] last_idx;
        logic       eom;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

/* rtl/core/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the position within the group of three and the
// leftover bits, and builds one character command per byte.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output b64e_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] POS_0 = 2'd0;
    localparam logic [1:0] POS_1 = 2'd1;
    localparam logic [1:0] POS_2 = 2'd2;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [3:0] r_left;
    logic [3:0] n_left;

    always_comb begin
        o_cmd     = '0;
        o_cmd.eom = i_last;
        n_pos     = r_pos;
        n_left    = r_left;
        case (r_pos)
            POS_1: begin
                o_cmd.sx0 = {r_left[1:0], i_byte[7:4]};
                if (i_last) begin
                    o_cmd.sx1      = {i_byte[3:0], 2'b00};
                    o_cmd.last_idx = 2'd2;
                    n_pos          = POS_0;
                    n_left         = 4'd0;
                end else begin
                    o_cmd.last_idx = 2'd0;
                    n_pos          = POS_2;
                    n_left         = i_byte[3:0];
                end
            end
            POS_2: begin
                o_cmd.sx0      = {r_left, i_byte[7:6]};
                o_cmd.sx1      = i_byte[5:0];
                o_cmd.last_idx = 2'd1;
                n_pos          = POS_0;
                n_left         = 4'd0;
            end
            default: begin
                o_cmd.sx0 = i_byte[7:2];
                if (i_last) begin
                    o_cmd.sx1      = {i_byte[1:0], 4'b0000};
                    o_cmd.last_idx = 2'd3;
                    n_pos          = POS_0;
                    n_left         = 4'd0;
                end else begin
                    o_cmd.last_idx = 2'd0;
                    n_pos          = POS_1;
                    n_left         = {2'b00, i_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_0;
            r_left <= 4'd0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

/* rtl/core/b64e_fifo.sv */
// ----------------------------------------------------------------------------
// b64e_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module b64e_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64e_pkg::t_cmd        i_push_cmd,
    input  logic                  i_pop,
    output b64e_pkg::t_cmd        o_head,
    output b64e_pkg::t_q_status   o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

/* rtl/core/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head command to the output register, one char per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64e_pkg::t_cmd        i_head,
    input  b64e_pkg::t_q_status   i_status,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_char,
    output logic                  o_eom
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_eom;
    logic       load;
    logic       emit;
    logic       at_end;
    logic [7:0] n_char;

    assign load   = !r_valid || i_ready;
    assign emit   = load && !i_status.empty;
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = emit && at_end;

    always_comb begin
        case (r_idx)
            2'd0:    n_char = b64e_pkg::sextet_char(i_head.sx0);
            2'd1:    n_char = b64e_pkg::sextet_char(i_head.sx1);
            default: n_char = b64e_pkg::PAD_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_status.empty;
            if (emit) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= n_char;
            r_eom  <= i_head.eom && at_end;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_eom   = r_eom;

endmodule

/* rtl/core/base64_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Byte stream to standard Base64 character stream encoder.
//
// Input channel s_*: one byte per item in s_tdata, s_tlast marks the last
// byte of a message. Output channel m_*: one ASCII character per item in
// m_tdata, m_tlast on the final character of the encoded message.
// The front takes a byte in every cycle that the command queue has room
// and turns it into one command of one to four characters. The back emits
// one character per cycle from the queue head into the output register
// while the receiver is not stalling. With an empty queue, the first
// character of an accepted byte is written into the queue, then loaded
// into the output register that drives m_tvalid. The output port sets the
// rate at one character per cycle; N bytes yield 4*ceil(N/3) characters.
// Reset: clears the group position, leftover bits, queue and output valid.
// A stalled receiver holds the output register; the queue then fills and
// s_tready drops until characters drain.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    b64e_pkg::t_cmd      front_cmd;
    b64e_pkg::t_cmd      head_cmd;
    b64e_pkg::t_q_status q_status;
    logic                accept;
    logic                pop;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_cmd    (front_cmd)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_push_cmd (front_cmd),
        .i_pop      (pop),
        .o_head     (head_cmd),
        .o_status   (q_status)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_cmd),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_char   (m_tdata),
        .o_eom    (m_tlast)
    );

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Base64 stream encoder. A directed set of short
// messages covers the padding cases and the alphabet ends, then random
// messages run through three phases of sender and receiver idling, with one
// long receiver hold-off that fills the encoder and stalls its input. Every
// accepted byte is encoded by a local model, and each emitted character is
// checked in order against it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int N_DIRECTED      = 19;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    typedef struct {
        logic [7:0] code;
        logic       eom;
    } b64_char_t;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;

    msg_byte_t  pending_bytes[$];
    b64_char_t  expected_chars[$];

    logic [1:0] group_pos = 2'd0;
    logic [3:0] carry_bits = 4'd0;

    int total_bytes = 0;
    int bytes_sent  = 0;
    int fail_count  = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    base64_stream_encoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic eom);
        b64_char_t c;
        c.code = code;
        c.eom  = eom;
        expected_chars.push_back(c);
    endfunction

    function automatic void encode_byte(input logic [7:0] data, input logic last);
        case (group_pos)
            2'd1: begin
                push_char(b64_char({carry_bits[1:0], data[7:4]}), 1'b0);
                carry_bits = data[3:0];
                if (last) begin
                    push_char(b64_char({carry_bits, 2'b00}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    group_pos  = 2'd0;
                    carry_bits = 4'd0;
                end else begin
                    group_pos = 2'd2;
                end
            end
            2'd2: begin
                push_char(b64_char({carry_bits, data[7:6]}), 1'b0);
                push_char(b64_char(data[5:0]), last);
                group_pos  = 2'd0;
                carry_bits = 4'd0;
            end
            default: begin
                push_char(b64_char(data[7:2]), 1'b0);
                carry_bits = {2'b00, data[1:0]};
                if (last) begin
                    push_char(b64_char({carry_bits[1:0], 4'b0000}), 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b0);
                    push_char(b64e_pkg::PAD_CHAR, 1'b1);
                    group_pos  = 2'd0;
                    carry_bits = 4'd0;
                end else begin
                    group_pos = 2'd1;
                end
            end
        endcase
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic last);
        msg_byte_t b;
        b.data = data;
        b.last = last;
        pending_bytes.push_back(b);
    endfunction

    always_comb begin
        if (bytes_sent < total_bytes / 3) begin
            tx_idle_pct = 26;
            rx_idle_pct = 85;
        end else if (bytes_sent < (2 * total_bytes) / 3) begin
            tx_idle_pct = 85;
            rx_idle_pct = 26;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    initial begin
        logic [7:0] directed_data[N_DIRECTED] = '{
            8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h4D, 8'h61, 8'h6E,
            8'hF8, 8'hFB, 8'hEF, 8'hFF, 8'h14, 8'hFB, 8'h9C, 8'h03, 8'hD9
        };
        logic directed_last[N_DIRECTED] = '{
            1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
            1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
        };
        int random_bytes;
        int msg_len;

        random_bytes = 0;
        for (int i = 0; i < N_DIRECTED; i++) begin
            queue_byte(directed_data[i], directed_last[i]);
        end
        while (random_bytes < 231) begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            for (int i = 0; i < msg_len; i++) begin
                queue_byte(8'($urandom_range(255)), i == msg_len - 1);
            end
            random_bytes += msg_len;
        end
        total_bytes = pending_bytes.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                offer = (pending_bytes.size() > 0) && ($urandom_range(99) >= tx_idle_pct);
                if (offer) begin
                    s_tdata <= pending_bytes[0].data;
                    s_tlast <= pending_bytes[0].last;
                    pending_bytes.pop_front();
                end
                s_tvalid <= offer;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_sent >= (2 * total_bytes) / 3) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        b64_char_t exp_c;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: out_char=%h end_of_message=%b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                exp_c = expected_chars.pop_front();
                if (m_tdata !== exp_c.code) begin
                    $error("out_char mismatch: expected %h actual %h", exp_c.code, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== exp_c.eom) begin
                    $error("end_of_message mismatch: expected %b actual %b", exp_c.eom, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (bytes_sent < total_bytes || expected_chars.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() > 0) begin
            $error("%0d expected characters never emitted", expected_chars.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Test completed with failures");
        $finish;
    end

endmodule
